// ===== hdl/tts_pkg.sv =====
// Shared types and constants for the TLV tag search block.
// Used by the channel interfaces, the parser, the output buffer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [BYTE_W-1:0] LONG_LEN_MARK = 8'h82;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TAG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd1;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd255;

	typedef enum logic [2:0] {
		PH_TAG   = 3'd0,
		PH_LEN   = 3'd1,
		PH_LHI   = 3'd2,
		PH_LLO   = 3'd3,
		PH_SKIP  = 3'd4,
		PH_VALUE = 3'd5,
		PH_DONE  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_VALUE    = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_TOOLONG  = 2'd3
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              file_start;
		logic              file_end;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] value_byte;
		status_t           status;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] target_tag;
		logic [LEN_W-1:0]  max_value_length;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hdl/tts_if.sv =====
// Valid/ready channel interfaces: file bytes in, search results out, register writes.
// Depends on tts_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tts_item_if;
	logic                       valid;
	logic                       ready;
	logic [tts_pkg::BYTE_W-1:0] data_byte;
	logic                       file_start;
	logic                       file_end;

	modport source (output valid, data_byte, file_start, file_end, input ready);
	modport sink   (input valid, data_byte, file_start, file_end, output ready);
endinterface

interface tts_result_if;
	logic                       valid;
	logic                       ready;
	logic [tts_pkg::BYTE_W-1:0] value_byte;
	logic [1:0]                 status;
	logic                       last;

	modport source (output valid, value_byte, status, last, input ready);
	modport sink   (input valid, value_byte, status, last, output ready);
endinterface

interface tts_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tts_pkg::CFG_IDX_W-1:0] index;
	logic [tts_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tts_parser.sv =====
// Record parser: holds the walk state and decides the result for each accepted byte.
// Depends on tts_pkg for phase, item, result and config types.
`timescale 1ns / 1ps
`default_nettype none

module tts_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire tts_pkg::item_t   item,
	input  wire tts_pkg::cfg_t    cfg,
	output tts_pkg::result_t      res,
	output logic                  res_vld
);

	tts_pkg::phase_t                phase_q, phase_d;
	logic                           tag_matched_q, tag_matched_d;
	logic [tts_pkg::BYTE_W-1:0]     length_high_q, length_high_d;
	logic [tts_pkg::LEN_W-1:0]      bytes_left_q, bytes_left_d;

	tts_pkg::phase_t                ph;
	logic                           tm;
	logic [tts_pkg::BYTE_W-1:0]     lh;
	logic [tts_pkg::LEN_W-1:0]      bl;
	logic [tts_pkg::LEN_W-1:0]      bl_dec;
	logic [tts_pkg::LEN_W-1:0]      len;

	always_comb begin
		// a file start restarts the walk before this byte is looked at
		ph = item.file_start ? tts_pkg::PH_TAG : phase_q;
		tm = item.file_start ? 1'b0 : tag_matched_q;
		lh = item.file_start ? '0 : length_high_q;
		bl = item.file_start ? '0 : bytes_left_q;
		bl_dec = bl - tts_pkg::LEN_W'(1);
		len = (ph == tts_pkg::PH_LLO) ? {lh, item.data_byte}
			: {{(tts_pkg::LEN_W-tts_pkg::BYTE_W){1'b0}}, item.data_byte};

		phase_d = ph;
		tag_matched_d = tm;
		length_high_d = lh;
		bytes_left_d = bl;
		res_vld = 1'b0;
		res.value_byte = '0;
		res.status = tts_pkg::ST_NOTFOUND;
		res.last = 1'b1;

		case (ph)
			tts_pkg::PH_TAG: begin
				tag_matched_d = (item.data_byte == cfg.target_tag);
				phase_d = tts_pkg::PH_LEN;
			end
			tts_pkg::PH_LHI: begin
				length_high_d = item.data_byte;
				phase_d = tts_pkg::PH_LLO;
			end
			tts_pkg::PH_LEN, tts_pkg::PH_LLO: begin
				if (ph == tts_pkg::PH_LEN && item.data_byte == tts_pkg::LONG_LEN_MARK) begin
					phase_d = tts_pkg::PH_LHI;
				end else if (tm) begin
					if (len == '0) begin
						phase_d = tts_pkg::PH_DONE;
						res_vld = 1'b1;
						res.status = tts_pkg::ST_EMPTY;
					end else if (len > cfg.max_value_length) begin
						phase_d = tts_pkg::PH_DONE;
						res_vld = 1'b1;
						res.status = tts_pkg::ST_TOOLONG;
					end else begin
						bytes_left_d = len;
						phase_d = tts_pkg::PH_VALUE;
					end
				end else if (len == '0) begin
					phase_d = tts_pkg::PH_TAG;
				end else begin
					bytes_left_d = len;
					phase_d = tts_pkg::PH_SKIP;
				end
			end
			tts_pkg::PH_SKIP: begin
				bytes_left_d = bl_dec;
				if (bl_dec == '0)
					phase_d = tts_pkg::PH_TAG;
			end
			tts_pkg::PH_VALUE: begin
				bytes_left_d = bl_dec;
				res_vld = 1'b1;
				if (bl_dec == '0) begin
					phase_d = tts_pkg::PH_DONE;
					res.value_byte = item.data_byte;
					res.status = tts_pkg::ST_VALUE;
				end else if (item.file_end) begin
					// value cut short by the end of the file
					phase_d = tts_pkg::PH_DONE;
				end else begin
					res.value_byte = item.data_byte;
					res.status = tts_pkg::ST_VALUE;
					res.last = 1'b0;
				end
			end
			default: begin
				phase_d = ph;
			end
		endcase

		if (!res_vld && item.file_end && phase_d != tts_pkg::PH_DONE) begin
			phase_d = tts_pkg::PH_DONE;
			res_vld = 1'b1;
			res.status = tts_pkg::ST_NOTFOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tts_pkg::PH_TAG;
			tag_matched_q <= 1'b0;
			length_high_q <= '0;
			bytes_left_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			tag_matched_q <= tag_matched_d;
			length_high_q <= length_high_d;
			bytes_left_q <= bytes_left_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tts_out_buf.sv =====
// Registered result stage with one skid entry, so the input side runs while a result waits.
// Depends on tts_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module tts_out_buf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire tts_pkg::result_t push_data,
	output logic                  can_push,
	output logic                  out_vld,
	input  wire logic             out_rdy,
	output tts_pkg::result_t      out_data
);

	logic             main_vld_q, skid_vld_q;
	tts_pkg::result_t main_q, skid_q;
	logic             pop;

	assign pop      = main_vld_q && out_rdy;
	assign can_push = !skid_vld_q;
	assign out_vld  = main_vld_q;
	assign out_data = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_vld_q || pop) begin
				main_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (pop) begin
			main_vld_q <= 1'b0;
		end
	end

	// payload: advance skid into main on a pop, else load the pushed result
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (push) begin
			if (!main_vld_q || pop)
				main_q <= push_data;
			else
				skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tlv_tag_search.sv =====
// TLV tag search top level: configuration registers, record parser and result stage.
// Depends on tts_pkg, tts_if, tts_parser and tts_out_buf.
//
// Usage:
//   item   - file bytes, one per transaction, with file_start on the first byte
//            and file_end on the last. Each byte walks the tag/length/value records.
//   result - value bytes of the matching record (status 0, last on the final one)
//            or a single status transaction: found empty, not found or too long.
//            A value cut short ends with a not-found status. After the final
//            result, bytes are dropped until the next file_start.
//   cfg    - register writes (index 0 target_tag, index 1 max_value_length),
//            always ready; write only while the block is idle.
// A result is registered in the result stage, passing through the skid entry
// when the main entry still waits. Throughput: one byte per cycle while item
// ready is high, set by the parser logic between walk state and result stage.
// When the receiver stalls, one further result is held in a skid entry; item
// ready then drops until the waiting result is taken.
// Reset clears the walk state so the first byte is read as a tag, sets
// target_tag to 0 and max_value_length to 255, and empties the result stage.
`timescale 1ns / 1ps
`default_nettype none

module tlv_tag_search (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tts_item_if.sink    item,
	tts_result_if.source result,
	tts_cfg_if.sink     cfg
);

	tts_pkg::cfg_t    cfg_q;
	tts_pkg::item_t   item_in;
	tts_pkg::result_t res, res_out;
	logic             res_vld;
	logic             can_push;
	logic             accept;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_tag <= '0;
			cfg_q.max_value_length <= tts_pkg::MAX_LEN_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				tts_pkg::CFG_TARGET_TAG: cfg_q.target_tag <= cfg.data[tts_pkg::BYTE_W-1:0];
				tts_pkg::CFG_MAX_LEN:    cfg_q.max_value_length <= cfg.data;
				default:                 cfg_q <= cfg_q;
			endcase
		end
	end

	assign item.ready = can_push;
	assign accept = item.valid && can_push;

	assign item_in.data_byte  = item.data_byte;
	assign item_in.file_start = item.file_start;
	assign item_in.file_end   = item.file_end;

	tts_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item_in),
		.cfg     (cfg_q),
		.res     (res),
		.res_vld (res_vld)
	);

	tts_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_vld),
		.push_data (res),
		.can_push  (can_push),
		.out_vld   (result.valid),
		.out_rdy   (result.ready),
		.out_data  (res_out)
	);

	assign result.value_byte = res_out.value_byte;
	assign result.status     = res_out.status;
	assign result.last       = res_out.last;

endmodule

`default_nettype wire

// ===== hdl/tts_checker.sv =====
// Port-level checks for tlv_tag_search, bound to the top level.
// Depends on tts_pkg for widths and status codes.
`timescale 1ns / 1ps
`default_nettype none

module tts_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       item_ready,
	input wire logic                       res_valid,
	input wire logic                       res_ready,
	input wire logic [tts_pkg::BYTE_W-1:0] res_value_byte,
	input wire logic [1:0]                 res_status,
	input wire logic                       res_last
);

	// a pending result holds until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before it was taken");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != tts_pkg::ST_VALUE |-> res_last)
		else $error("status result without last");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != tts_pkg::ST_VALUE |-> res_value_byte == '0)
		else $error("status result carries a value byte");

	// input side stalls only when a result is backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> res_valid)
		else $error("item stalled with no pending result");

endmodule

bind tlv_tag_search tts_checker u_tts_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_ready     (item.ready),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_value_byte (result.value_byte),
	.res_status     (result.status),
	.res_last       (result.last)
);

`default_nettype wire
